// ----- src/spq_pkg.sv -----
// shared types and codes for the sorted array priority queue
// no dependencies
package spq_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

// ----- src/spq_in_if.sv -----
// input channel of the priority queue: valid/ready plus operation and value
// no dependencies
interface spq_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [VALUE_BITS-1:0] item_value;

    modport source (output valid, operation, item_value, input ready);
    modport sink   (input valid, operation, item_value, output ready);
endinterface

// ----- src/spq_out_if.sv -----
// result channel of the priority queue: valid/ready plus status, count and head
// no dependencies
interface spq_out_if #(
    parameter int VALUE_BITS = 16,
    parameter int COUNT_BITS = 7
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [COUNT_BITS-1:0]        entry_count;
    logic                         head_valid;
    logic signed [VALUE_BITS-1:0] head_value;

    modport source (output valid, status, entry_count, head_valid, head_value, input ready);
    modport sink   (input valid, status, entry_count, head_valid, head_value, output ready);
endinterface

// ----- src/sorted_array_priority_queue.sv -----
// sorted array priority queue, top level: a row of spq_cell slots plus count and result register
// depends on spq_pkg, spq_in_if, spq_out_if, spq_cell
//
// usage:
//   in_ch carries an operation (insert or delete) and a signed value; out_ch returns
//   one item per input item with status (ok, overflow, empty, not found), the entry
//   count after the operation, and the head (largest value, zero when empty).
//   every slot compares the broadcast value in parallel and shifts to its neighbor,
//   so each operation finishes in the cycle it is accepted.
//   the result is registered and is presented in the cycle after acceptance.
//   throughput: one item per cycle while the receiver takes results, set by the compare and shift row.
//   the result register frees the input side: a new item is taken whenever the
//   result register is empty or being drained in the same cycle.
//   when the receiver stalls, the result holds and the input stalls after one item.
//   reset clears the count and the result valid; slot contents are not cleared,
//   values in slots beyond the count never reach the result.
module sorted_array_priority_queue #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input logic       clk,
    input logic       rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);
    import spq_pkg::*;

    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic [COUNT_BITS-1:0]        entry_count_reg;
    logic                         head_valid_reg;
    logic signed [VALUE_BITS-1:0] head_value_reg;

    logic                         accept;
    logic                         full;
    logic                         found;
    cell_ctrl_t                   ctrl;

    logic [DEPTH-1:0]             take;
    logic [DEPTH-1:0]             match;
    logic [DEPTH-1:0]             occupied;
    logic signed [VALUE_BITS-1:0] value [DEPTH];
    logic signed [VALUE_BITS-1:0] value_next [DEPTH];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = (count_reg == COUNT_BITS'(DEPTH));
    assign found       = |match;

    assign ctrl.ins_en = accept && (in_ch.operation == OP_INSERT) && !full;
    assign ctrl.del_en = accept && (in_ch.operation == OP_DELETE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occupied[gi] = (COUNT_BITS'(gi) < count_reg);
            spq_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[gi]),
                .new_value  (in_ch.item_value),
                .prev_take  ((gi == 0) ? 1'b0 : take[(gi == 0) ? 0 : gi - 1]),
                .prev_value (value[(gi == 0) ? 0 : gi - 1]),
                .succ_value (value[(gi == DEPTH - 1) ? gi : gi + 1]),
                .take       (take[gi]),
                .match      (match[gi]),
                .value      (value[gi]),
                .value_next (value_next[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        if (in_ch.operation == OP_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                status_next = STATUS_EMPTY;
            end
            else if (!found)
            begin
                status_next = STATUS_NOT_FOUND;
            end
            else
            begin
                count_next = count_reg - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= count_next;
            head_valid_reg  <= (count_next != '0);
            head_value_reg  <= (count_next != '0) ? value_next[0] : '0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.entry_count = entry_count_reg;
    assign out_ch.head_valid  = head_valid_reg;
    assign out_ch.head_value  = head_value_reg;

endmodule

// ----- src/spq_cell.sv -----
// one slot of the sorted row: compares against the broadcast value and shifts
// depends on spq_pkg
module spq_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         clk,
    input  spq_pkg::cell_ctrl_t          ctrl,
    input  logic                         occupied,
    input  logic signed [VALUE_BITS-1:0] new_value,
    input  logic                         prev_take,
    input  logic signed [VALUE_BITS-1:0] prev_value,
    input  logic signed [VALUE_BITS-1:0] succ_value,
    output logic                         take,
    output logic                         match,
    output logic signed [VALUE_BITS-1:0] value,
    output logic signed [VALUE_BITS-1:0] value_next
);
    import spq_pkg::*;

    logic signed [VALUE_BITS-1:0] value_reg;
    logic                         pull;

    // insert point: first slot that is free or not above the new value
    assign take  = !occupied || (new_value >= value_reg);
    // delete: every occupied slot at or below the value pulls from its successor
    assign pull  = occupied && (value_reg <= new_value);
    assign match = occupied && (value_reg == new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en)
        begin
            if (prev_take)
            begin
                value_next = prev_value;
            end
            else if (take)
            begin
                value_next = new_value;
            end
        end
        else if (ctrl.del_en && pull)
        begin
            value_next = succ_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- src/spq_checker.sv -----
// port-level checks for the sorted array priority queue, bound to the top level
// depends on spq_pkg and sorted_array_priority_queue
module spq_checker #(
    parameter int DEPTH      = 64,
    parameter int COUNT_BITS = 7
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            status,
    input logic [COUNT_BITS-1:0] entry_count,
    input logic                  head_valid
);
    import spq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (entry_count != '0)))
        else $error("head valid disagrees with entry count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= COUNT_BITS'(DEPTH)))
        else $error("entry count beyond depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OVERFLOW) |-> (entry_count == COUNT_BITS'(DEPTH)))
        else $error("overflow reported while not full");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY) |-> (entry_count == '0) && !head_valid)
        else $error("empty reported with entries stored");

endmodule

bind sorted_array_priority_queue spq_checker #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
) u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .entry_count (out_ch.entry_count),
    .head_valid  (out_ch.head_valid)
);
